### design/assert_macros.svh
// Assertion helpers for the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed")
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed")
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, prop)
`endif

`endif

### design/isms_pkg.sv
`timescale 1ns / 1ps

package isms_pkg;

   localparam logic [1:0] REQ_SET  = 2'd0;
   localparam logic [1:0] REQ_GET  = 2'd1;
   localparam logic [1:0] REQ_FIND = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [47:0] block;
      logic [48:0] window_end;
      logic [4:0]  status_code;
   } req_beat_type;

   typedef struct packed {
      logic [4:0]  status_out;
      logic        found;
      logic [47:0] range_first;
      logic [48:0] range_end;
      logic        table_full;
   } rsp_beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EDIT,
      ST_DONE
   } state_type;

   // How the rewrite pass shifts entries at and behind the edit point.
   typedef enum logic [2:0] {
      MODE_KEEP,
      MODE_DEL1,
      MODE_DEL2,
      MODE_INS1,
      MODE_INS2
   } edit_mode_type;

   typedef enum logic [1:0] {
      FLD_NONE,
      FLD_START,
      FLD_LIMIT,
      FLD_STATUS
   } field_type;

endpackage

### design/isms_cell.sv
`timescale 1ns / 1ps

module isms_cell #(
   parameter int AW         = 49,
   parameter int BLOCK_BITS = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          shift_en,
   input  logic [AW-1:0] start_d,
   input  logic [AW-1:0] limit_d,
   input  logic [4:0]    status_d,
   output logic [AW-1:0] start_q,
   output logic [AW-1:0] limit_q,
   output logic [4:0]    status_q
);

   logic [AW-1:0] start_ff;
   logic [AW-1:0] limit_ff;
   logic [4:0]    status_ff;

   // Every cell resets to the single range covering the whole space; only the
   // head copy matters, the rest lie beyond the fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         limit_ff  <= AW'(1) << BLOCK_BITS;
         status_ff <= '0;
      end else if (shift_en) begin
         start_ff  <= start_d;
         limit_ff  <= limit_d;
         status_ff <= status_d;
      end
   end

   assign start_q  = start_ff;
   assign limit_q  = limit_ff;
   assign status_q = status_ff;

endmodule

### design/interval_status_map.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake               Beat
// req      in         req_valid / req_ready   isms_pkg::req_beat_type
// rsp      out        rsp_valid / rsp_ready   isms_pkg::rsp_beat_type
//
// The range table lives in a ring of MAX_RANGES cells that rotates one entry
// per cycle during the scan and edit laps. Every request makes one full lap to
// locate, get and find; a set that changes the table makes a second lap that
// rewrites the ring.
// Reset is synchronous and active high; it leaves one range of status zero.
// A new request is accepted while the previous result still waits in rsp.

module interval_status_map #(
   parameter int MAX_RANGES = 256,
   parameter int BLOCK_BITS = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  isms_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output isms_pkg::rsp_beat_type rsp_data
);

`include "assert_macros.svh"

   localparam int AW   = (BLOCK_BITS + 1 > 49) ? BLOCK_BITS + 1 : 49;
   localparam int TW   = $clog2(MAX_RANGES);
   localparam int CNTW = $clog2(MAX_RANGES + 1);

   logic [AW-1:0] c_start  [MAX_RANGES];
   logic [AW-1:0] c_limit  [MAX_RANGES];
   logic [4:0]    c_status [MAX_RANGES];

   logic [AW-1:0] push_start;
   logic [AW-1:0] push_limit;
   logic [4:0]    push_status;
   logic          shift_en;

   isms_pkg::state_type    state_ff, state_in;
   isms_pkg::req_beat_type req_ff;
   isms_pkg::rsp_beat_type rsp_ff, rsp_in;
   logic                   rsp_valid_ff;
   logic [TW-1:0]          t_ff;
   logic [CNTW-1:0]        count_ff;

   // Two-deep history of the head entry, used for inserts and the left neighbor.
   logic [AW-1:0] d1_start_ff, d1_limit_ff, d2_start_ff, d2_limit_ff;
   logic [4:0]    d1_status_ff, d2_status_ff;

   // Scan captures.
   logic [TW-1:0] idx_ff;
   logic [AW-1:0] cur_start_ff, cur_limit_ff, nxt_limit_ff;
   logic [4:0]    cur_status_ff, prv_status_ff, nxt_status_ff;
   logic          nxt_ok_ff;
   logic          fdone_ff, found_ff;
   logic [AW-1:0] first_ff, end_ff;

   // Edit record for the rewrite lap.
   isms_pkg::edit_mode_type mode_ff, mode_in;
   isms_pkg::field_type     ova_fld_ff, ova_fld_in;
   logic [CNTW-1:0] pos_p_ff, pos_p_in, new_pos_ff, new_pos_in;
   logic [CNTW-1:0] ova_pos_ff, ova_pos_in, ovb_pos_ff, ovb_pos_in;
   logic            new_en_ff, new_en_in, ovb_en_ff, ovb_en_in;
   logic [AW-1:0]   ova_val_ff, ova_val_in, ovb_val_ff, ovb_val_in;
   logic [CNTW-1:0] count_new_ff, count_new_in;
   logic            full_in, full_ff, do_edit;

   logic [CNTW-1:0] t_ext;
   logic            last_t, valid_t;
   logic [AW-1:0]   blk_e, blk1_e, we_e, space_end, x2;
   logic            in_space;

   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      if (i == MAX_RANGES - 1) begin : g_tail
         isms_cell #(.AW(AW), .BLOCK_BITS(BLOCK_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift_en(shift_en),
            .start_d(push_start), .limit_d(push_limit), .status_d(push_status),
            .start_q(c_start[i]), .limit_q(c_limit[i]), .status_q(c_status[i]));
      end else begin : g_body
         isms_cell #(.AW(AW), .BLOCK_BITS(BLOCK_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift_en(shift_en),
            .start_d(c_start[i+1]), .limit_d(c_limit[i+1]), .status_d(c_status[i+1]),
            .start_q(c_start[i]), .limit_q(c_limit[i]), .status_q(c_status[i]));
      end
   end

   assign t_ext     = CNTW'(t_ff);
   assign last_t    = (t_ff == TW'(MAX_RANGES - 1));
   assign valid_t   = (t_ext < count_ff);
   assign blk_e     = AW'(req_ff.block);
   assign blk1_e    = blk_e + AW'(1);
   assign we_e      = AW'(req_ff.window_end);
   assign space_end = AW'(1) << BLOCK_BITS;
   assign in_space  = (blk_e < space_end);
   assign x2        = (c_limit[0] > we_e) ? we_e : c_limit[0];
   assign shift_en  = (state_ff == isms_pkg::ST_SCAN) || (state_ff == isms_pkg::ST_EDIT);

   // Stream editor: what goes back into the tail of the ring this cycle.
   always_comb begin
      logic past_p;
      past_p      = (t_ext >= pos_p_ff);
      push_start  = c_start[0];
      push_limit  = c_limit[0];
      push_status = c_status[0];
      if (state_ff == isms_pkg::ST_EDIT) begin
         if (past_p) begin
            case (mode_ff)
               isms_pkg::MODE_DEL1: begin
                  push_start  = c_start[1];
                  push_limit  = c_limit[1];
                  push_status = c_status[1];
               end
               isms_pkg::MODE_DEL2: begin
                  push_start  = c_start[2];
                  push_limit  = c_limit[2];
                  push_status = c_status[2];
               end
               isms_pkg::MODE_INS1: begin
                  push_start  = d1_start_ff;
                  push_limit  = d1_limit_ff;
                  push_status = d1_status_ff;
               end
               isms_pkg::MODE_INS2: begin
                  push_start  = d2_start_ff;
                  push_limit  = d2_limit_ff;
                  push_status = d2_status_ff;
               end
               default: begin
               end
            endcase
         end
         if (new_en_ff && t_ext == new_pos_ff) begin
            push_start  = blk_e;
            push_limit  = blk1_e;
            push_status = req_ff.status_code;
         end
         if (t_ext == ova_pos_ff) begin
            case (ova_fld_ff)
               isms_pkg::FLD_START:  push_start  = ova_val_ff;
               isms_pkg::FLD_LIMIT:  push_limit  = ova_val_ff;
               isms_pkg::FLD_STATUS: push_status = req_ff.status_code;
               default: begin
               end
            endcase
         end
         if (ovb_en_ff && t_ext == ovb_pos_ff) begin
            push_start = ovb_val_ff;
         end
      end
   end

   // Work out the rewrite from the located range and its neighbors.
   always_comb begin
      logic          prev_eq, next_eq, one;
      logic [CNTW-1:0] idx_c, idx_m1, idx_p1, idx_p2;
      idx_c  = CNTW'(idx_ff);
      idx_m1 = idx_c - CNTW'(1);
      idx_p1 = idx_c + CNTW'(1);
      idx_p2 = idx_c + CNTW'(2);
      prev_eq = (idx_ff != '0) && (prv_status_ff == req_ff.status_code);
      next_eq = nxt_ok_ff && (nxt_status_ff == req_ff.status_code);
      one     = ((cur_limit_ff - cur_start_ff) == AW'(1));
      mode_in      = isms_pkg::MODE_KEEP;
      pos_p_in     = idx_c;
      new_en_in    = 1'b0;
      new_pos_in   = idx_c;
      ova_fld_in   = isms_pkg::FLD_NONE;
      ova_pos_in   = idx_c;
      ova_val_in   = blk_e;
      ovb_en_in    = 1'b0;
      ovb_pos_in   = idx_c;
      ovb_val_in   = blk1_e;
      count_new_in = count_ff;
      full_in      = 1'b0;
      do_edit      = 1'b0;
      if (req_ff.req_type == isms_pkg::REQ_SET && in_space &&
          cur_status_ff != req_ff.status_code) begin
         do_edit = 1'b1;
         if (one) begin
            if (prev_eq && next_eq) begin
               mode_in      = isms_pkg::MODE_DEL2;
               ova_fld_in   = isms_pkg::FLD_LIMIT;
               ova_pos_in   = idx_m1;
               ova_val_in   = nxt_limit_ff;
               count_new_in = count_ff - CNTW'(2);
            end else if (prev_eq) begin
               mode_in      = isms_pkg::MODE_DEL1;
               ova_fld_in   = isms_pkg::FLD_LIMIT;
               ova_pos_in   = idx_m1;
               ova_val_in   = cur_limit_ff;
               count_new_in = count_ff - CNTW'(1);
            end else if (next_eq) begin
               mode_in      = isms_pkg::MODE_DEL1;
               ova_fld_in   = isms_pkg::FLD_START;
               ova_val_in   = cur_start_ff;
               count_new_in = count_ff - CNTW'(1);
            end else begin
               ova_fld_in = isms_pkg::FLD_STATUS;
            end
         end else if (blk_e == cur_start_ff && prev_eq) begin
            ova_fld_in = isms_pkg::FLD_LIMIT;
            ova_pos_in = idx_m1;
            ova_val_in = blk1_e;
            ovb_en_in  = 1'b1;
         end else if (blk1_e == cur_limit_ff && next_eq) begin
            ova_fld_in = isms_pkg::FLD_LIMIT;
            ova_val_in = blk_e;
            ovb_en_in  = 1'b1;
            ovb_pos_in = idx_p1;
            ovb_val_in = blk_e;
         end else if (blk_e == cur_start_ff) begin
            if (count_ff == CNTW'(MAX_RANGES)) begin
               full_in = 1'b1;
               do_edit = 1'b0;
            end else begin
               mode_in      = isms_pkg::MODE_INS1;
               new_en_in    = 1'b1;
               ovb_en_in    = 1'b1;
               ovb_pos_in   = idx_p1;
               count_new_in = count_ff + CNTW'(1);
            end
         end else if (blk1_e == cur_limit_ff) begin
            if (count_ff == CNTW'(MAX_RANGES)) begin
               full_in = 1'b1;
               do_edit = 1'b0;
            end else begin
               mode_in      = isms_pkg::MODE_INS1;
               pos_p_in     = idx_p1;
               new_en_in    = 1'b1;
               new_pos_in   = idx_p1;
               ova_fld_in   = isms_pkg::FLD_LIMIT;
               count_new_in = count_ff + CNTW'(1);
            end
         end else begin
            if (count_ff >= CNTW'(MAX_RANGES - 1)) begin
               full_in = 1'b1;
               do_edit = 1'b0;
            end else begin
               mode_in      = isms_pkg::MODE_INS2;
               pos_p_in     = idx_p1;
               new_en_in    = 1'b1;
               new_pos_in   = idx_p1;
               ova_fld_in   = isms_pkg::FLD_LIMIT;
               ovb_en_in    = 1'b1;
               ovb_pos_in   = idx_p2;
               count_new_in = count_ff + CNTW'(2);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         isms_pkg::ST_IDLE: begin
            if (req_valid) state_in = isms_pkg::ST_SCAN;
         end
         isms_pkg::ST_SCAN: begin
            if (last_t) state_in = isms_pkg::ST_DECIDE;
         end
         isms_pkg::ST_DECIDE: begin
            state_in = do_edit ? isms_pkg::ST_EDIT : isms_pkg::ST_DONE;
         end
         isms_pkg::ST_EDIT: begin
            if (last_t) state_in = isms_pkg::ST_DONE;
         end
         isms_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = isms_pkg::ST_IDLE;
         end
         default: state_in = isms_pkg::ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == isms_pkg::ST_IDLE);

   always_comb begin
      rsp_in = '0;
      case (req_ff.req_type)
         isms_pkg::REQ_SET: rsp_in.table_full = full_ff;
         isms_pkg::REQ_GET: begin
            if (in_space) rsp_in.status_out = cur_status_ff;
         end
         isms_pkg::REQ_FIND: begin
            if (found_ff) begin
               rsp_in.found       = 1'b1;
               rsp_in.range_first = first_ff[47:0];
               rsp_in.range_end   = end_ff[48:0];
            end
         end
         default: rsp_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= CNTW'(1);
         t_ff         <= '0;
         fdone_ff     <= 1'b0;
         found_ff     <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         if (state_ff == isms_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // The position counter wraps with the lap so a second lap starts at zero.
         if (shift_en) t_ff <= last_t ? '0 : t_ff + TW'(1);
         if (state_ff == isms_pkg::ST_IDLE && req_valid) begin
            t_ff     <= '0;
            fdone_ff <= 1'b0;
            found_ff <= 1'b0;
            full_ff  <= 1'b0;
         end
         if (state_ff == isms_pkg::ST_SCAN && valid_t && !fdone_ff) begin
            if (c_start[0] >= we_e) begin
               fdone_ff <= 1'b1;
            end else if (c_status[0] == req_ff.status_code &&
                         ((c_start[0] <= blk_e && blk_e < x2) || blk_e <= c_start[0])) begin
               fdone_ff <= 1'b1;
               found_ff <= 1'b1;
            end
         end
         if (state_ff == isms_pkg::ST_DECIDE) full_ff <= full_in;
         if (state_ff == isms_pkg::ST_EDIT && last_t) count_ff <= count_new_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == isms_pkg::ST_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == isms_pkg::ST_DONE && (!rsp_valid_ff || rsp_ready)) rsp_ff <= rsp_in;
      if (shift_en) begin
         d1_start_ff  <= c_start[0];
         d1_limit_ff  <= c_limit[0];
         d1_status_ff <= c_status[0];
         d2_start_ff  <= d1_start_ff;
         d2_limit_ff  <= d1_limit_ff;
         d2_status_ff <= d1_status_ff;
      end
      // Starts ascend, so the last entry starting at or below the block holds it.
      if (state_ff == isms_pkg::ST_SCAN && valid_t && c_start[0] <= blk_e) begin
         idx_ff        <= t_ff;
         cur_start_ff  <= c_start[0];
         cur_limit_ff  <= c_limit[0];
         cur_status_ff <= c_status[0];
         prv_status_ff <= d1_status_ff;
         nxt_limit_ff  <= c_limit[1];
         nxt_status_ff <= c_status[1];
         nxt_ok_ff     <= ((t_ext + CNTW'(1)) < count_ff);
      end
      if (state_ff == isms_pkg::ST_SCAN && valid_t && !fdone_ff &&
          c_start[0] < we_e && c_status[0] == req_ff.status_code) begin
         first_ff <= (c_start[0] <= blk_e) ? blk_e : c_start[0];
         end_ff   <= x2;
      end
      if (state_ff == isms_pkg::ST_DECIDE) begin
         mode_ff      <= mode_in;
         pos_p_ff     <= pos_p_in;
         new_en_ff    <= new_en_in;
         new_pos_ff   <= new_pos_in;
         ova_fld_ff   <= ova_fld_in;
         ova_pos_ff   <= ova_pos_in;
         ova_val_ff   <= ova_val_in;
         ovb_en_ff    <= ovb_en_in;
         ovb_pos_ff   <= ovb_pos_in;
         ovb_val_ff   <= ovb_val_in;
         count_new_ff <= count_new_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_count_range, clock, reset,
      count_ff != '0 && count_ff <= CNTW'(MAX_RANGES));
   `ASSERT_IMPLIES(a_rsp_from_done, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == isms_pkg::ST_DONE));
   `ASSERT_IMPLIES(a_count_only_in_edit, clock, reset,
      (state_ff != isms_pkg::ST_EDIT) |=> $stable(count_ff));
   `ASSERT_IMPLIES(a_no_accept_busy, clock, reset,
      (state_ff != isms_pkg::ST_IDLE) |-> !req_ready);

endmodule

### tb/sv/interval_status_map_checker.sv
`timescale 1ns / 1ps

module interval_status_map_checker #(
   parameter int MAX_RANGES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  isms_pkg::req_beat_type req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  isms_pkg::rsp_beat_type rsp_data,
   output int                     fail_count,
   output int                     outstanding,
   output int                     refusals,
   output int                     hits
);

   localparam logic [48:0] SPACE_END = 49'h1_0000_0000_0000;

   // Shadow copy of the range table.
   logic [48:0] shadow_start [MAX_RANGES];
   logic [48:0] shadow_limit [MAX_RANGES];
   logic [4:0]  shadow_status [MAX_RANGES];
   int          shadow_count;

   isms_pkg::rsp_beat_type expected_rsps [$];

   function automatic int find_index(logic [48:0] blk);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = shadow_count;
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         if (blk < shadow_start[mid]) hi = mid;
         else lo = mid;
      end
      return lo;
   endfunction

   function automatic void write_entry(int i, logic [48:0] s, logic [48:0] l, logic [4:0] st);
      shadow_start[i] = s;
      shadow_limit[i] = l;
      shadow_status[i] = st;
   endfunction

   function automatic void remove_entries(int at, int n);
      for (int i = at; i + n < shadow_count; i++)
         write_entry(i, shadow_start[i + n], shadow_limit[i + n], shadow_status[i + n]);
      shadow_count -= n;
   endfunction

   function automatic void insert_entries(int at, int n);
      for (int i = shadow_count; i > at; i--)
         write_entry(i - 1 + n, shadow_start[i - 1], shadow_limit[i - 1], shadow_status[i - 1]);
      shadow_count += n;
   endfunction

   // Returns 1 when the change is refused for lack of room.
   function automatic bit update_status(logic [47:0] block, logic [4:0] st);
      logic [48:0] blk;
      logic [48:0] s;
      logic [48:0] l;
      logic [4:0]  old;
      int          idx;
      bit          prev_eq;
      bit          next_eq;
      blk = {1'b0, block};
      idx = find_index(blk);
      s = shadow_start[idx];
      l = shadow_limit[idx];
      old = shadow_status[idx];
      if (old == st) return 0;
      prev_eq = idx > 0 && shadow_status[idx - 1] == st;
      next_eq = idx + 1 < shadow_count && shadow_status[idx + 1] == st;
      if (l - s == 1) begin
         if (prev_eq && next_eq) begin
            shadow_limit[idx - 1] = shadow_limit[idx + 1];
            remove_entries(idx, 2);
         end else if (prev_eq) begin
            shadow_limit[idx - 1] = l;
            remove_entries(idx, 1);
         end else if (next_eq) begin
            shadow_start[idx + 1] = s;
            remove_entries(idx, 1);
         end else begin
            shadow_status[idx] = st;
         end
         return 0;
      end
      if (blk == s && prev_eq) begin
         shadow_limit[idx - 1] = blk + 1;
         shadow_start[idx] = blk + 1;
         return 0;
      end
      if (blk + 1 == l && next_eq) begin
         shadow_limit[idx] = blk;
         shadow_start[idx + 1] = blk;
         return 0;
      end
      if (blk == s) begin
         if (shadow_count + 1 > MAX_RANGES) return 1;
         insert_entries(idx, 1);
         write_entry(idx, blk, blk + 1, st);
         shadow_start[idx + 1] = blk + 1;
         return 0;
      end
      if (blk + 1 == l) begin
         if (shadow_count + 1 > MAX_RANGES) return 1;
         insert_entries(idx + 1, 1);
         shadow_limit[idx] = blk;
         write_entry(idx + 1, blk, blk + 1, st);
         return 0;
      end
      if (shadow_count + 2 > MAX_RANGES) return 1;
      insert_entries(idx + 1, 2);
      shadow_limit[idx] = blk;
      write_entry(idx + 1, blk, blk + 1, st);
      write_entry(idx + 2, blk + 1, l, old);
      return 0;
   endfunction

   function automatic isms_pkg::rsp_beat_type predict_answer(isms_pkg::req_beat_type req);
      isms_pkg::rsp_beat_type ans;
      logic [48:0]  wb;
      logic [48:0]  x1;
      logic [48:0]  x2;
      ans = '0;
      wb = {1'b0, req.block};
      case (req.req_type)
         isms_pkg::REQ_SET: ans.table_full = update_status(req.block, req.status_code);
         isms_pkg::REQ_GET: ans.status_out = shadow_status[find_index(wb)];
         isms_pkg::REQ_FIND: begin
            for (int i = 0; i < shadow_count; i++) begin
               x1 = shadow_start[i];
               x2 = shadow_limit[i];
               if (x1 >= req.window_end) break;
               if (x2 > req.window_end) x2 = req.window_end;
               if (shadow_status[i] != req.status_code) continue;
               if (x1 <= wb && wb < x2) begin
                  ans.found = 1'b1;
                  ans.range_first = wb[47:0];
                  ans.range_end = x2;
                  break;
               end
               if (wb <= x1 && x1 < req.window_end) begin
                  ans.found = 1'b1;
                  ans.range_first = x1[47:0];
                  ans.range_end = x2;
                  break;
               end
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   task automatic compare_field(string name, logic [48:0] exp_v, logic [48:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      isms_pkg::rsp_beat_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < MAX_RANGES; i++) write_entry(i, '0, '0, '0);
         write_entry(0, '0, SPACE_END, '0);
         shadow_count = 1;
         expected_rsps.delete();
         fail_count = 0;
         outstanding = 0;
         refusals = 0;
         hits = 0;
      end else begin
         if (req_valid && req_ready) begin
            exp_rsp = predict_answer(req_data);
            if (exp_rsp.table_full) refusals++;
            if (exp_rsp.found) hits++;
            expected_rsps.push_back(exp_rsp);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result beat arrived with nothing expected");
               fail_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               compare_field("status_out", 49'(exp_rsp.status_out), 49'(rsp_data.status_out));
               compare_field("found", 49'(exp_rsp.found), 49'(rsp_data.found));
               compare_field("range_first", 49'(exp_rsp.range_first),
                             49'(rsp_data.range_first));
               compare_field("range_end", exp_rsp.range_end, rsp_data.range_end);
               compare_field("table_full", 49'(exp_rsp.table_full), 49'(rsp_data.table_full));
            end
         end
         outstanding = expected_rsps.size();
      end
   end

endmodule

### tb/sv/interval_status_map_tb.sv
`timescale 1ns / 1ps

module interval_status_map_tb;

   localparam logic [1:0]  REQ_UNUSED = 2'd3;
   localparam logic [47:0] BLOCK_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [48:0] SPACE_END = 49'h1_0000_0000_0000;
   localparam int RANDOM_BEATS = 1880;
   localparam longint CYCLE_LIMIT = 12_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   isms_pkg::req_beat_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   isms_pkg::rsp_beat_type rsp_data;

   int     fail_count;
   int     outstanding;
   int     refusals;
   int     hits;
   longint cycle_count = 0;
   int     sets_sent = 0;
   int     gets_sent = 0;
   int     finds_sent = 0;

   always #2 clock = ~clock;

   interval_status_map dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   interval_status_map_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .outstanding(outstanding),
      .refusals(refusals), .hits(hits)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("interval_status_map_tb failed");
         $finish;
      end
   end

   // The receiver alternates between long ready stretches and choppy stalls.
   always @(posedge clock) begin
      case ((cycle_count / 3000) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 40) > 30);
      endcase
   end

   task automatic send_beat(logic [1:0] kind, logic [47:0] blk, logic [48:0] wend,
                            logic [4:0] st);
      req_valid <= 1'b1;
      req_data <= '{req_type: kind, block: blk, window_end: wend, status_code: st};
      do @(posedge clock); while (!req_ready);
      case (kind)
         isms_pkg::REQ_SET: sets_sent++;
         isms_pkg::REQ_GET: gets_sent++;
         isms_pkg::REQ_FIND: finds_sent++;
         default: ;
      endcase
   endtask

   task automatic pause_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Mostly a narrow region so merges and splits interact; now and then the full space.
   function automatic logic [47:0] pick_block();
      case ($urandom_range(0, 9))
         0: return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
         1: return BLOCK_MAX - $urandom_range(0, 3);
         default: return 48'(32'h1000 + $urandom_range(0, 600));
      endcase
   endfunction

   task automatic send_random_beat();
      logic [47:0] blk;
      logic [48:0] wend;
      logic [4:0]  st;
      int          pick;
      blk = pick_block();
      st = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 5))
         0: wend = {1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)), $urandom()};
         1: wend = SPACE_END;
         2: wend = {1'b0, blk} - $urandom_range(0, 2);
         default: wend = {1'b0, blk} + $urandom_range(1, 400);
      endcase
      if (pick < 50) begin
         send_beat(isms_pkg::REQ_SET, blk, {1'($urandom_range(0, 1)), $urandom(), 16'h0}, st);
      end else if (pick < 72) send_beat(isms_pkg::REQ_GET, blk, wend, st);
      else if (pick < 98) send_beat(isms_pkg::REQ_FIND, blk, wend, st);
      else send_beat(REQ_UNUSED, blk, wend, st);
   endtask

   initial begin
      int sent;
      int burst;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(isms_pkg::REQ_GET, '0, '0, 5'd0);
      send_beat(isms_pkg::REQ_GET, BLOCK_MAX, '0, 5'd0);
      send_beat(isms_pkg::REQ_FIND, '0, SPACE_END, 5'd0);
      send_beat(isms_pkg::REQ_SET, '0, '0, 5'd31);
      send_beat(isms_pkg::REQ_SET, BLOCK_MAX, '1, 5'd5);
      send_beat(isms_pkg::REQ_SET, 48'd1000, '0, 5'd5);
      // Same status again leaves the table alone.
      send_beat(isms_pkg::REQ_SET, 48'd1000, '0, 5'd5);
      send_beat(isms_pkg::REQ_SET, 48'd1001, '0, 5'd5);
      send_beat(isms_pkg::REQ_SET, 48'd999, '0, 5'd5);
      send_beat(isms_pkg::REQ_SET, 48'd1000, '0, 5'd7);
      // A single block between two equal neighbors merges all three.
      send_beat(isms_pkg::REQ_SET, 48'd1000, '0, 5'd5);
      send_beat(isms_pkg::REQ_GET, 48'd1000, '0, 5'd0);
      send_beat(isms_pkg::REQ_FIND, 48'd990, 49'd1010, 5'd5);
      send_beat(isms_pkg::REQ_FIND, 48'd1000, 49'd1000, 5'd5);
      send_beat(isms_pkg::REQ_FIND, 48'd1000, 49'd10, 5'd0);
      send_beat(isms_pkg::REQ_FIND, 48'd2, SPACE_END, 5'd31);
      send_beat(isms_pkg::REQ_FIND, 48'd1, SPACE_END, 5'd5);
      send_beat(isms_pkg::REQ_FIND, BLOCK_MAX, '1, 5'd5);
      send_beat(REQ_UNUSED, BLOCK_MAX, '1, 5'd31);
      send_beat(isms_pkg::REQ_SET, 48'd1, '0, 5'd31);
      send_beat(isms_pkg::REQ_GET, 48'd0, '0, 5'd0);
      drain_results();

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 8);
         for (int i = 0; i < burst && sent < RANDOM_BEATS; i++) begin
            send_random_beat();
            sent++;
         end
         if (sent % 400 < burst) drain_results();
         else if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 300));
      end
      drain_results();
      repeat (600) @(posedge clock);

      $display("Covered %0d sets (%0d refused on a full table), %0d gets, %0d finds (%0d hits).",
               sets_sent, refusals, gets_sent, finds_sent, hits);
      if (fail_count == 0) begin
         $display("interval_status_map_tb passed");
      end else begin
         $display("interval_status_map_tb failed");
      end
      $finish;
   end

endmodule
